[hdl/rvalu_pkg.sv]
// ----------------------------------------------------------------------------
// rvalu_pkg
// Shared types, opcode fields and helpers of the RV64IM integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvalu_pkg;

  localparam int unsigned XLEN       = 64;
  localparam int unsigned HALF       = XLEN / 2;
  localparam int unsigned MUL_STAGES = 4;
  // decode register, multiplier stages, one cell per quotient bit, output register
  localparam int unsigned LATENCY    = 1 + MUL_STAGES + XLEN + 1;

  typedef enum logic [1:0] {
    KIND_OP_IMM   = 2'd0,
    KIND_OP       = 2'd1,
    KIND_OP_IMM_W = 2'd2,
    KIND_OP_W     = 2'd3
  } kind_e;

  // base integer funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // multiply / divide funct3 codes
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [5:0] F6_BASE   = 6'h00;
  localparam logic [5:0] F6_SRA    = 6'h10;

  typedef struct packed {
    logic            valid;
    logic            illegal;
    logic            is_div;
    logic            rem_sel;
    logic            negq;
    logic            negr;
    logic            word;
    logic [XLEN-1:0] side;
  } ctl_t;

  typedef struct packed {
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic            is_mul;
    logic            hi;
    logic            sa;
    logic            sb;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
  } mul_t;

  function automatic logic [XLEN-1:0] sext32(input logic [HALF-1:0] v);
    return {{HALF{v[HALF-1]}}, v};
  endfunction

endpackage

`default_nettype wire

[hdl/rv64im_integer_alu.sv]
// ----------------------------------------------------------------------------
// rv64im_integer_alu
// RV64IM integer execute unit: base ops, multiply and a pipelined divider.
// ----------------------------------------------------------------------------
//  channel   ports                                              direction
//  command   start_i, busy_o, kind_i, funct3_i, funct7_i,       in
//            operand_a_i, operand_b_i
//  result    done_o, result_value_o, illegal_o                  out
//
//  from transfer to its done_o strobe every item passes one decode
//  register, four multiplier stages, 64 division cells, one output register
//  a new command is taken every cycle; busy_o stays low
//  the division chain sets the latency; all operations walk it so results
//  leave in the order the commands came in
//  reset clears the valid flags of all stages; results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module rv64im_integer_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 kind_i,
  input  logic [2:0]                 funct3_i,
  input  logic [6:0]                 funct7_i,
  input  logic [rvalu_pkg::XLEN-1:0] operand_a_i,
  input  logic [rvalu_pkg::XLEN-1:0] operand_b_i,
  output logic                       done_o,
  output logic [rvalu_pkg::XLEN-1:0] result_value_o,
  output logic                       illegal_o
);
  import rvalu_pkg::*;

  ctl_t            dec_ctl, ctl_c [XLEN+1];
  div_t            dec_div, div_c [XLEN+1];
  mul_t            dec_mul;
  ctl_t            fin;
  logic [XLEN-1:0] q, r, dv, res_d, res_q;
  logic            done_q, ill_q;

  // decode, base results, divider operand magnitudes
  rvalu_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .kind_i      (kind_i),
    .funct3_i    (funct3_i),
    .funct7_i    (funct7_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .ctl_o       (dec_ctl),
    .div_o       (dec_div),
    .mul_o       (dec_mul)
  );

  // multiplier; its product replaces the side result for mul ops
  rvalu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dec_ctl),
    .div_i  (dec_div),
    .mul_i  (dec_mul),
    .ctl_o  (ctl_c[0]),
    .div_o  (div_c[0])
  );

  // division chain, one quotient bit per cell, msb first
  for (genvar g = 0; g < XLEN; g++) begin : g_cell
    rvalu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[g]),
      .div_i  (div_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .div_o  (div_c[g+1])
    );
  end

  // sign fix-up of quotient or remainder, word results re-extended
  always_comb begin
    fin = ctl_c[XLEN];
    q   = div_c[XLEN].quo;
    r   = div_c[XLEN].rem;
    if (fin.rem_sel) dv = fin.negr ? (XLEN'(0) - r) : r;
    else dv = fin.negq ? (XLEN'(0) - q) : q;
    if (fin.word) dv = sext32(dv[HALF-1:0]);
    if (fin.illegal) res_d = '0;
    else if (fin.is_div) res_d = dv;
    else res_d = fin.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ill_q <= fin.illegal;
  end

  assign busy_o         = 1'b0;
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign illegal_o      = ill_q;

endmodule

`default_nettype wire

[hdl/rvalu_dec.sv]
// ----------------------------------------------------------------------------
// rvalu_dec
// Decode register: legality, base-op results and divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_dec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [1:0]                 kind_i,
  input  logic [2:0]                 funct3_i,
  input  logic [6:0]                 funct7_i,
  input  logic [rvalu_pkg::XLEN-1:0] operand_a_i,
  input  logic [rvalu_pkg::XLEN-1:0] operand_b_i,
  output rvalu_pkg::ctl_t            ctl_o,
  output rvalu_pkg::div_t            div_o,
  output rvalu_pkg::mul_t            mul_o
);
  import rvalu_pkg::*;

  kind_e           kind;
  logic [XLEN-1:0] a, b, res, xa, xb;
  logic [5:0]      sh64;
  logic [4:0]      sh32;
  logic [HALF-1:0] sllw_w, srlw_w, sraw_w;
  logic            illegal, is_mul, mul_hi, sa, sb, is_div, rem_sel, dsigned, na, nb, bz;
  ctl_t            ctl_d, ctl_q;
  div_t            div_d, div_q;
  mul_t            mul_d, mul_q;

  assign a      = operand_a_i;
  assign b      = operand_b_i;
  assign kind   = kind_e'(kind_i);
  assign sh64   = b[5:0];
  assign sh32   = b[4:0];
  assign sllw_w = a[HALF-1:0] << sh32;
  assign srlw_w = a[HALF-1:0] >> sh32;
  assign sraw_w = HALF'($signed(a[HALF-1:0]) >>> sh32);

  always_comb begin
    illegal = 1'b0;
    res     = '0;
    is_mul  = 1'b0;
    mul_hi  = 1'b0;
    sa      = 1'b0;
    sb      = 1'b0;
    is_div  = 1'b0;
    rem_sel = 1'b0;
    dsigned = 1'b0;
    unique case (kind)
      KIND_OP_IMM: begin
        case (funct3_i)
          F3_ADD:  res = a + b;
          F3_SLT:  res = XLEN'($signed(a) < $signed(b));
          F3_SLTU: res = XLEN'(a < b);
          F3_XOR:  res = a ^ b;
          F3_OR:   res = a | b;
          F3_SLL: begin
            if (funct7_i[6:1] == F6_BASE) res = a << sh64;
            else illegal = 1'b1;
          end
          F3_SR: begin
            if (funct7_i[6:1] == F6_BASE) res = a >> sh64;
            else if (funct7_i[6:1] == F6_SRA) res = XLEN'($signed(a) >>> sh64);
            else illegal = 1'b1;
          end
          default: res = a & b;
        endcase
      end
      KIND_OP: begin
        if (funct7_i == F7_MULDIV) begin
          if (funct3_i[2]) begin
            is_div  = 1'b1;
            dsigned = (funct3_i == F3_DIV) || (funct3_i == F3_REM);
            rem_sel = (funct3_i == F3_REM) || (funct3_i == F3_REMU);
          end else begin
            is_mul = 1'b1;
            mul_hi = (funct3_i != F3_MUL);
            sa     = (funct3_i == F3_MULH) || (funct3_i == F3_MULHSU);
            sb     = (funct3_i == F3_MULH);
          end
        end else if (funct7_i == F7_ALT) begin
          if (funct3_i == F3_ADD) res = a - b;
          else if (funct3_i == F3_SR) res = XLEN'($signed(a) >>> sh64);
          else illegal = 1'b1;
        end else if (funct7_i == F7_BASE) begin
          case (funct3_i)
            F3_ADD:  res = a + b;
            F3_SLL:  res = a << sh64;
            F3_SLT:  res = XLEN'($signed(a) < $signed(b));
            F3_SLTU: res = XLEN'(a < b);
            F3_XOR:  res = a ^ b;
            F3_SR:   res = a >> sh64;
            F3_OR:   res = a | b;
            default: res = a & b;
          endcase
        end else begin
          illegal = 1'b1;
        end
      end
      KIND_OP_IMM_W: begin
        if (funct3_i == F3_ADD) res = sext32(a[HALF-1:0] + b[HALF-1:0]);
        else if (funct3_i == F3_SLL && funct7_i == F7_BASE) res = sext32(sllw_w);
        else if (funct3_i == F3_SR && funct7_i == F7_BASE) res = sext32(srlw_w);
        else if (funct3_i == F3_SR && funct7_i == F7_ALT) res = sext32(sraw_w);
        else illegal = 1'b1;
      end
      default: begin
        if (funct7_i == F7_MULDIV) begin
          if (funct3_i == F3_MUL) begin
            is_mul = 1'b1;
          end else if (funct3_i[2]) begin
            is_div  = 1'b1;
            dsigned = (funct3_i == F3_DIV) || (funct3_i == F3_REM);
            rem_sel = (funct3_i == F3_REM) || (funct3_i == F3_REMU);
          end else begin
            illegal = 1'b1;
          end
        end else if (funct7_i == F7_ALT) begin
          if (funct3_i == F3_ADD) res = sext32(a[HALF-1:0] - b[HALF-1:0]);
          else if (funct3_i == F3_SR) res = sext32(sraw_w);
          else illegal = 1'b1;
        end else if (funct7_i == F7_BASE) begin
          if (funct3_i == F3_ADD) res = sext32(a[HALF-1:0] + b[HALF-1:0]);
          else if (funct3_i == F3_SLL) res = sext32(sllw_w);
          else if (funct3_i == F3_SR) res = sext32(srlw_w);
          else illegal = 1'b1;
        end else begin
          illegal = 1'b1;
        end
      end
    endcase
  end

  // divider operands: magnitudes, word forms first extended from the low half
  always_comb begin
    if (kind_i[1]) begin
      xa = dsigned ? sext32(a[HALF-1:0]) : {{HALF{1'b0}}, a[HALF-1:0]};
      xb = dsigned ? sext32(b[HALF-1:0]) : {{HALF{1'b0}}, b[HALF-1:0]};
    end else begin
      xa = a;
      xb = b;
    end
    na = dsigned & xa[XLEN-1];
    nb = dsigned & xb[XLEN-1];
    bz = (xb == '0);
  end

  always_comb begin
    ctl_d.valid   = start_i;
    ctl_d.illegal = illegal;
    ctl_d.is_div  = is_div;
    ctl_d.rem_sel = rem_sel;
    ctl_d.negq    = (na ^ nb) & ~bz;
    ctl_d.negr    = na;
    ctl_d.word    = kind_i[1];
    ctl_d.side    = res;
    div_d.rem     = '0;
    div_d.quo     = na ? (XLEN'(0) - xa) : xa;
    div_d.dvs     = nb ? (XLEN'(0) - xb) : xb;
    mul_d.is_mul  = is_mul;
    mul_d.hi      = mul_hi;
    mul_d.sa      = sa;
    mul_d.sb      = sb;
    mul_d.a       = a;
    mul_d.b       = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    mul_q <= mul_d;
  end

  assign ctl_o = ctl_q;
  assign div_o = div_q;
  assign mul_o = mul_q;

endmodule

`default_nettype wire

[hdl/rvalu_mul.sv]
// ----------------------------------------------------------------------------
// rvalu_mul
// Four-stage 64x64 multiplier from 32x32 partial products; carries the item.
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rvalu_pkg::ctl_t ctl_i,
  input  rvalu_pkg::div_t div_i,
  input  rvalu_pkg::mul_t mul_i,
  output rvalu_pkg::ctl_t ctl_o,
  output rvalu_pkg::div_t div_o
);
  import rvalu_pkg::*;

  ctl_t              ctl_q [MUL_STAGES];
  div_t              div_q [MUL_STAGES];
  logic [1:0]        sel_q [MUL_STAGES-1];
  logic [XLEN-1:0]   corr_q [MUL_STAGES-1];
  logic [XLEN-1:0]   ll_q, lh_q, hl_q, hh_q, ll2_q, hh2_q;
  logic [XLEN:0]     mid_q;
  logic [2*XLEN-1:0] prod_q;
  logic [XLEN-1:0]   corr_d, mul_res;
  ctl_t              last_d;

  assign corr_d = ((mul_i.sa & mul_i.a[XLEN-1]) ? mul_i.b : '0)
                + ((mul_i.sb & mul_i.b[XLEN-1]) ? mul_i.a : '0);

  // sel: {is_mul, hi}
  always_ff @(posedge clk_i) begin
    ll_q      <= mul_i.a[HALF-1:0] * mul_i.b[HALF-1:0];
    lh_q      <= mul_i.a[HALF-1:0] * mul_i.b[XLEN-1:HALF];
    hl_q      <= mul_i.a[XLEN-1:HALF] * mul_i.b[HALF-1:0];
    hh_q      <= mul_i.a[XLEN-1:HALF] * mul_i.b[XLEN-1:HALF];
    corr_q[0] <= corr_d;
    sel_q[0]  <= {mul_i.is_mul, mul_i.hi};
    mid_q     <= {1'b0, lh_q} + {1'b0, hl_q};
    ll2_q     <= ll_q;
    hh2_q     <= hh_q;
    prod_q    <= {hh2_q, ll2_q} + {{(HALF-1){1'b0}}, mid_q, {HALF{1'b0}}};
    for (int i = 1; i < MUL_STAGES - 1; i++) begin
      corr_q[i] <= corr_q[i-1];
      sel_q[i]  <= sel_q[i-1];
    end
  end

  always_comb begin
    if (sel_q[MUL_STAGES-2][0]) begin
      mul_res = prod_q[2*XLEN-1:XLEN] - corr_q[MUL_STAGES-2];
    end else if (ctl_q[MUL_STAGES-2].word) begin
      mul_res = sext32(prod_q[HALF-1:0]);
    end else begin
      mul_res = prod_q[XLEN-1:0];
    end
    last_d = ctl_q[MUL_STAGES-2];
    if (sel_q[MUL_STAGES-2][1]) last_d.side = mul_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MUL_STAGES; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < MUL_STAGES - 1; i++) ctl_q[i] <= ctl_q[i-1];
      ctl_q[MUL_STAGES-1] <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= div_i;
    for (int i = 1; i < MUL_STAGES; i++) div_q[i] <= div_q[i-1];
  end

  assign ctl_o = ctl_q[MUL_STAGES-1];
  assign div_o = div_q[MUL_STAGES-1];

endmodule

`default_nettype wire

[hdl/rvalu_cell.sv]
// ----------------------------------------------------------------------------
// rvalu_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rvalu_pkg::ctl_t ctl_i,
  input  rvalu_pkg::div_t div_i,
  output rvalu_pkg::ctl_t ctl_o,
  output rvalu_pkg::div_t div_o
);
  import rvalu_pkg::*;

  logic [XLEN:0]   shifted;
  logic [XLEN+1:0] diff;
  logic            ge;
  div_t            div_d, div_q;
  ctl_t            ctl_q;

  assign shifted = {div_i.rem, div_i.quo[XLEN-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_i.dvs};
  assign ge      = ~diff[XLEN+1];

  always_comb begin
    div_d.rem = ge ? diff[XLEN-1:0] : shifted[XLEN-1:0];
    div_d.quo = {div_i.quo[XLEN-2:0], ge};
    div_d.dvs = div_i.dvs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign ctl_o = ctl_q;
  assign div_o = div_q;

endmodule

`default_nettype wire

[hdl/rvalu_chk.sv]
// ----------------------------------------------------------------------------
// rvalu_chk
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rvalu_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [rvalu_pkg::XLEN-1:0] result_value_o,
  input logic                       illegal_o
);
  import rvalu_pkg::*;

  // each transfer yields a result after the fixed latency
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result missing after transfer");

  // no result without a transfer at the matching cycle
  a_lat_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching transfer");

  // illegal encodings return zero
  a_ill_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && illegal_o) |-> (result_value_o == '0))
    else $error("illegal result not zero");

endmodule

bind rv64im_integer_alu rvalu_chk u_rvalu_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .illegal_o      (illegal_o)
);

`default_nettype wire

[tb/rv64im_integer_alu_tb.sv]
// ----------------------------------------------------------------------------
// rv64im_integer_alu_tb
// Self-checking bench for the RV64IM execute unit: commands go in as bursts
// with random gaps, an in-bench predictor computes each result and a monitor
// compares every done_o strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64im_integer_alu_tb;
  import rvalu_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4 * LATENCY + 200;

  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            bad;
  } alu_res_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  logic            busy_o;
  logic [1:0]      kind_i = '0;
  logic [2:0]      funct3_i = '0;
  logic [6:0]      funct7_i = '0;
  logic [XLEN-1:0] operand_a_i = '0;
  logic [XLEN-1:0] operand_b_i = '0;
  logic            done_o;
  logic [XLEN-1:0] result_value_o;
  logic            illegal_o;

  alu_res_t pending_results[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;

  rv64im_integer_alu dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---- predictor helpers ----
  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [XLEN-1:0] sdiv(input logic [XLEN-1:0] a, b, input bit want_rem);
    logic [XLEN-1:0] ua, ub, q, r;
    if (b == '0) return want_rem ? a : '1;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q  = ua / ub;
    r  = ua % ub;
    if (want_rem) return a[63] ? -r : r;
    return (a[63] ^ b[63]) ? -q : q;
  endfunction

  // full 128-bit products, signedness chosen per operand
  function automatic logic [XLEN-1:0] mul_high(input logic [XLEN-1:0] a, b, input bit sa, sb);
    logic [127:0] ea, eb, p;
    ea = sa ? {{64{a[63]}}, a} : {64'd0, a};
    eb = sb ? {{64{b[63]}}, b} : {64'd0, b};
    p  = ea * eb;
    return p[127:64];
  endfunction

  function automatic alu_res_t predict_alu(input logic [1:0] kind, input logic [2:0] f3,
                                           input logic [6:0] f7,
                                           input logic [XLEN-1:0] a, b);
    alu_res_t        res;
    logic [XLEN-1:0] r;
    logic [5:0]      sh6;
    logic [4:0]      sh5;
    logic [XLEN-1:0] ua, ub;
    bit              ok;
    r = '0; ok = 1'b1;
    sh6 = b[5:0]; sh5 = b[4:0];
    ua = {32'd0, a[31:0]}; ub = {32'd0, b[31:0]};
    case (kind_e'(kind))
      KIND_OP_IMM: begin
        case (f3)
          F3_ADD:  r = a + b;
          F3_SLT:  r = {63'd0, $signed(a) < $signed(b)};
          F3_SLTU: r = {63'd0, a < b};
          F3_XOR:  r = a ^ b;
          F3_OR:   r = a | b;
          F3_AND:  r = a & b;
          F3_SLL:  if (f7[6:1] == F6_BASE) r = a << sh6; else ok = 1'b0;
          default: begin
            if (f7[6:1] == F6_BASE) r = a >> sh6;
            else if (f7[6:1] == F6_SRA) r = $signed(a) >>> sh6;
            else ok = 1'b0;
          end
        endcase
      end
      KIND_OP: begin
        if (f7 == F7_MULDIV) begin
          case (f3)
            F3_MUL:    r = a * b;
            F3_MULH:   r = mul_high(a, b, 1'b1, 1'b1);
            F3_MULHSU: r = mul_high(a, b, 1'b1, 1'b0);
            F3_MULHU:  r = mul_high(a, b, 1'b0, 1'b0);
            F3_DIV:    r = sdiv(a, b, 1'b0);
            F3_DIVU:   r = (b == '0) ? '1 : a / b;
            F3_REM:    r = sdiv(a, b, 1'b1);
            default:   r = (b == '0) ? a : a % b;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) r = a - b;
          else if (f3 == F3_SR) r = $signed(a) >>> sh6;
          else ok = 1'b0;
        end else if (f7 != F7_BASE) begin
          ok = 1'b0;
        end else begin
          case (f3)
            F3_ADD:  r = a + b;
            F3_SLL:  r = a << sh6;
            F3_SLT:  r = {63'd0, $signed(a) < $signed(b)};
            F3_SLTU: r = {63'd0, a < b};
            F3_XOR:  r = a ^ b;
            F3_SR:   r = a >> sh6;
            F3_OR:   r = a | b;
            default: r = a & b;
          endcase
        end
      end
      KIND_OP_IMM_W: begin
        if (f3 == F3_ADD) r = sx32(a + b);
        else if (f3 == F3_SLL && f7 == F7_BASE) r = sx32(a << sh5);
        else if (f3 == F3_SR && f7 == F7_BASE) r = sx32(ua >> sh5);
        else if (f3 == F3_SR && f7 == F7_ALT) r = $signed(sx32(a)) >>> sh5;
        else ok = 1'b0;
      end
      default: begin
        if (f7 == F7_MULDIV) begin
          case (f3)
            F3_MUL:  r = sx32(a * b);
            F3_DIV:  r = sx32(sdiv(sx32(a), sx32(b), 1'b0));
            F3_DIVU: r = (ub == '0) ? '1 : sx32(ua / ub);
            F3_REM:  r = sx32(sdiv(sx32(a), sx32(b), 1'b1));
            F3_REMU: r = sx32((ub == '0) ? ua : ua % ub);
            default: ok = 1'b0;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) r = sx32(a - b);
          else if (f3 == F3_SR) r = $signed(sx32(a)) >>> sh5;
          else ok = 1'b0;
        end else if (f7 != F7_BASE) begin
          ok = 1'b0;
        end else if (f3 == F3_ADD) r = sx32(a + b);
        else if (f3 == F3_SLL) r = sx32(a << sh5);
        else if (f3 == F3_SR) r = sx32(ua >> sh5);
        else ok = 1'b0;
      end
    endcase
    res.value = ok ? r : '0;
    res.bad   = !ok;
    return res;
  endfunction

  // ---- command driver: one transfer, random gaps between bursts ----
  task automatic send_command(input logic [1:0] kind, input logic [2:0] f3,
                              input logic [6:0] f7, input logic [XLEN-1:0] a, b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    start_i     <= 1'b1;
    kind_i      <= kind;
    funct3_i    <= f3;
    funct7_i    <= f7;
    operand_a_i <= a;
    operand_b_i <= b;
    // wait for the transfer edge
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_alu(kind, f3, f7, a, b));
    @(negedge clk_i);
  endtask

  // ---- result monitor ----
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result value=%h illegal=%b", $time, result_value_o,
                 illegal_o);
        error_count++;
      end else begin
        alu_res_t want;
        want = pending_results.pop_front();
        if (result_value_o !== want.value) begin
          $display("%0t result_value expected %h actual %h", $time, want.value,
                   result_value_o);
          error_count++;
        end
        if (illegal_o !== want.bad) begin
          $display("%0t illegal expected %b actual %b", $time, want.bad, illegal_o);
          error_count++;
        end
      end
    end
  end

  // ---- watchdog on cycles with no transfer on either side ----
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [XLEN-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operands biased toward corner values
  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return sx32({32'd0, 32'h8000_0000});
      5: return 64'(signed'($urandom_range(0, 20)) - 10);
      6: return {32'd0, $urandom()};
      default: return rand64();
    endcase
  endfunction

  function automatic logic [XLEN-1:0] imm12();
    logic [11:0] i;
    i = 12'($urandom());
    return {{52{i[11]}}, i};
  endfunction

  // ---- directed tests ----
  task automatic test_edges();
    send_command(KIND_OP, F3_ADD, F7_BASE, '1, '1);
    send_command(KIND_OP, F3_ADD, F7_ALT, '0, '1);
    send_command(KIND_OP_IMM, F3_SR, 7'h20, 64'h8000_0000_0000_0000, 64'd63);
    send_command(KIND_OP_IMM, F3_SR, 7'h21, '1, 64'd33);
    send_command(KIND_OP_IMM, F3_SLL, 7'h01, '1, 64'd32);
    send_command(KIND_OP_IMM, F3_SLL, 7'h02, '1, 64'd1);
    send_command(KIND_OP_IMM_W, F3_SR, F7_ALT, 64'h8000_0000, 64'd31);
    send_command(KIND_OP_IMM_W, F3_SR, 7'h01, 64'h8000_0000, 64'd32);
    send_command(KIND_OP, F3_SLT, 7'h7f, '1, '0);
  endtask

  task automatic test_divide_corners();
    send_command(KIND_OP, F3_DIV, F7_MULDIV, 64'h8000_0000_0000_0000, '1);
    send_command(KIND_OP, F3_REM, F7_MULDIV, 64'h8000_0000_0000_0000, '1);
    send_command(KIND_OP, F3_DIV, F7_MULDIV, 64'd7, '0);
    send_command(KIND_OP, F3_REMU, F7_MULDIV, 64'd7, '0);
    send_command(KIND_OP, F3_DIVU, F7_MULDIV, '1, '0);
    send_command(KIND_OP_W, F3_DIV, F7_MULDIV, 64'h8000_0000, '1);
    send_command(KIND_OP_W, F3_REM, F7_MULDIV, 64'h8000_0000, 64'hffff_ffff);
    send_command(KIND_OP_W, F3_DIVU, F7_MULDIV, 64'h5, 64'h1_0000_0000);
    send_command(KIND_OP_W, F3_REMU, F7_MULDIV, 64'h1_8000_0005, 64'h1_0000_0000);
    send_command(KIND_OP_W, F3_MULH, F7_MULDIV, 64'd3, 64'd3);
    send_command(KIND_OP, F3_MULH, F7_MULDIV, 64'h8000_0000_0000_0000, '1);
    send_command(KIND_OP, F3_MULHSU, F7_MULDIV, '1, '1);
    send_command(KIND_OP, F3_MULHU, F7_MULDIV, '1, '1);
  endtask

  // ---- random stream: mostly legal encodings, some raw noise ----
  task automatic test_random_stream(input int count);
    logic [1:0]      kind;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [4:0]      shamt;
    logic [XLEN-1:0] b;
    repeat (count) begin
      kind = 2'($urandom());
      f3   = 3'($urandom());
      case ($urandom_range(0, 9))
        0, 1, 2: f7 = F7_BASE;
        3, 4:    f7 = F7_ALT;
        5, 6, 7: f7 = F7_MULDIV;
        default: f7 = 7'($urandom());
      endcase
      b = kind[0] ? pick_operand() : imm12();
      // immediate shifts carry their funct bits inside the immediate
      if (!kind[0] && (f3 == F3_SLL || f3 == F3_SR) && $urandom_range(0, 3) != 0) begin
        f7 = ($urandom_range(0, 1) != 0) ? F7_ALT : F7_BASE;
        if (kind == KIND_OP_IMM) f7[0] = 1'($urandom());
        shamt = 5'($urandom_range(0, 31));
        b = {{52{f7[6]}}, f7, shamt};
      end
      send_command(kind, f3, f7, pick_operand(), b);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_edges();
    test_divide_corners();
    test_random_stream(1100);
    start_i <= 1'b0;
    // drain the pipeline
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/rvalu_pkg.sv
hdl/rvalu_dec.sv
hdl/rvalu_mul.sv
hdl/rvalu_cell.sv
hdl/rv64im_integer_alu.sv
hdl/rvalu_chk.sv
tb/rv64im_integer_alu_tb.sv
